### rtl/trapezoid_pi_integrator_defines.svh
// Assertion macros shared by the checker of the trapezoid pi integrator.
`ifndef TRAPEZOID_PI_INTEGRATOR_DEFINES_SVH
`define TRAPEZOID_PI_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define TPI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("trapezoid_pi_integrator: assertion failed");

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define TPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("trapezoid_pi_integrator: assertion failed");

`endif

### rtl/tpi_pkg.sv
// Package of the trapezoid pi integrator: widths, constants and the sequencer states.
`default_nettype none

package tpi_pkg;

  // Field widths of the request and result beats.
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned WIDTH_W    = 32;
  localparam int unsigned INTEGRAL_W = 32;

  // Number of trapezoid count bits the block honors.
  localparam int unsigned COUNT_BITS = 16;

  // Sample point register: holds i*w exactly in Q17.32, at least 49 bits so that
  // the overflow test on the rounded point always has bits to look at.
  localparam int unsigned X_W  = (COUNT_BITS + 33 > 49) ? COUNT_BITS + 33 : 49;
  localparam int unsigned XR_W = X_W + 1;
  localparam int unsigned ROUND_HALF = 32768;

  // Heights are Q3.29, the accumulator Q3.45.
  localparam int unsigned HEIGHT_W = 32;
  localparam int unsigned ACC_W    = 48;

  // Serial multiplier: 33-bit multiplicand, 32-bit multiplier, 65-bit product.
  localparam int unsigned PROD_W    = 65;
  localparam int unsigned MUL_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(MUL_STEPS);

  // Restoring divider for 2^63 / (2^32 + sq).
  localparam int unsigned DIV_W = 64;
  localparam logic [DIV_W-1:0] DIV_OFFSET = 64'h0000_0001_0000_0000;
  localparam logic [DIV_W-1:0] DIV_SEED   = 64'h0000_0000_8000_0000;

  // f(0) = 4.0 in Q3.29.
  localparam logic [HEIGHT_W-1:0] HEIGHT_AT_ZERO = 32'h8000_0000;
  localparam logic [ACC_W-1:0]    ACC_MAX        = {ACC_W{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_POINT,
    S_SQR,
    S_SQCHK,
    S_DIV,
    S_TSET,
    S_TRM,
    S_ACC,
    S_DONE
  } tpi_state_e;

endpackage

`default_nettype wire

### rtl/tpi_ifs.sv
// Valid/ready channel interfaces for the request and result beats.
`default_nettype none

interface tpi_req_if;
  logic                         valid;
  logic                         ready;
  logic [tpi_pkg::COUNT_W-1:0]  trapezoid_count;
  logic [tpi_pkg::WIDTH_W-1:0]  step_width;

  modport source (output valid, output trapezoid_count, output step_width, input ready);
  modport sink   (input valid, input trapezoid_count, input step_width, output ready);
endinterface

interface tpi_res_if;
  logic                            valid;
  logic                            ready;
  logic [tpi_pkg::INTEGRAL_W-1:0]  integral;

  modport source (output valid, output integral, input ready);
  modport sink   (input valid, input integral, output ready);
endinterface

`default_nettype wire

### rtl/trapezoid_pi_integrator.sv
// Top level of the trapezoid pi integrator: sequencer, bit-serial multiplier and divider.
`default_nettype none

// Each request beat carries a trapezoid count N and a step width w in unsigned Q0.32
// (normally 1/N). The block sums the trapezoid rule for 4/(1+x^2) over the points
// x_i = i*w, i = 0..N, and returns one result beat with the integral in unsigned Q3.29,
// saturating at full scale; a zero count or a zero width gives zero. One request is
// worked on at a time: the request channel is ready only while the block is idle,
// and a finished result waits in an output register so that the next request can be
// taken before the result is collected. Each trapezoid runs through the single
// bit-serial shift-add multiplier, once for the square of the sample point and once
// for the trapezoid term, and the restoring divider that forms 4/(1+x^2) one
// quotient bit a cycle, with the states POINT, SQCHK, TSET and ACC sequencing them.
// Far sample points skip the square and the divide.
module trapezoid_pi_integrator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tpi_req_if.sink     req_i,
  tpi_res_if.source   res_o
);

  localparam int unsigned CB = tpi_pkg::COUNT_BITS;

  // Sequencer state and output register (control, reset).
  tpi_pkg::tpi_state_e state_q, state_d;
  logic                res_valid_q;

  // Datapath registers (payload, no reset).
  logic [CB-1:0]                   n_q;
  logic [CB-1:0]                   trapezoid_index_q;
  logic [tpi_pkg::WIDTH_W-1:0]     w_q;
  logic [tpi_pkg::X_W-1:0]         x_q;
  logic [tpi_pkg::HEIGHT_W-1:0]    left_height_q;
  logic [tpi_pkg::HEIGHT_W-1:0]    quo_q;
  logic [tpi_pkg::ACC_W-1:0]       sum_accumulator_q;
  logic [tpi_pkg::PROD_W-1:0]      mcand_q;
  logic [tpi_pkg::MUL_STEPS-1:0]   mplier_q;
  logic [tpi_pkg::PROD_W-1:0]      prod_q;
  logic [tpi_pkg::DIV_W-1:0]       div_q;
  logic [tpi_pkg::DIV_W-1:0]       rem_q;
  logic [tpi_pkg::CNT_W-1:0]       bit_cnt_q;
  logic [tpi_pkg::INTEGRAL_W-1:0]  res_integral_q;

  // Combinational helpers.
  logic                           req_beat;
  logic                           res_load;
  logic                           count_zero;
  logic                           cnt_last;
  logic [tpi_pkg::XR_W-1:0]       x_round;
  logic                           x_far;
  logic                           sq_over;
  logic [tpi_pkg::DIV_W:0]        rem_shift;
  logic [tpi_pkg::DIV_W:0]        rem_diff;
  logic                           rem_ge;
  logic [tpi_pkg::ACC_W:0]        acc_sum;

  assign req_beat   = req_i.valid && req_i.ready;
  assign count_zero = (CB'(req_i.trapezoid_count) == '0);
  assign cnt_last   = (bit_cnt_q == tpi_pkg::CNT_W'(tpi_pkg::MUL_STEPS - 1));

  // Rounded sample point Q16.16; anything at or above 2^16 gives a zero height.
  assign x_round = {1'b0, x_q} + tpi_pkg::XR_W'(tpi_pkg::ROUND_HALF);
  assign x_far   = |x_round[tpi_pkg::XR_W-1:48];

  // The square beyond 2^63 also gives a zero height.
  assign sq_over = prod_q[63] && (|prod_q[62:0]);

  // One restoring division step: the dividend below the seed is all zeros.
  assign rem_shift = {rem_q, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, div_q};
  assign rem_ge    = (rem_shift >= {1'b0, div_q});

  // Trapezoid term is the product truncated to Q3.45, which folds in the factor 0.5.
  assign acc_sum = {1'b0, sum_accumulator_q} + {1'b0, prod_q[tpi_pkg::PROD_W-1:17]};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tpi_pkg::S_IDLE: begin
        if (req_beat) begin
          state_d = count_zero ? tpi_pkg::S_DONE : tpi_pkg::S_POINT;
        end
      end
      tpi_pkg::S_POINT: begin
        state_d = x_far ? tpi_pkg::S_TSET : tpi_pkg::S_SQR;
      end
      tpi_pkg::S_SQR: begin
        if (cnt_last) begin
          state_d = tpi_pkg::S_SQCHK;
        end
      end
      tpi_pkg::S_SQCHK: begin
        state_d = sq_over ? tpi_pkg::S_TSET : tpi_pkg::S_DIV;
      end
      tpi_pkg::S_DIV: begin
        if (cnt_last) begin
          state_d = tpi_pkg::S_TSET;
        end
      end
      tpi_pkg::S_TSET: begin
        state_d = tpi_pkg::S_TRM;
      end
      tpi_pkg::S_TRM: begin
        if (cnt_last) begin
          state_d = tpi_pkg::S_ACC;
        end
      end
      tpi_pkg::S_ACC: begin
        if (trapezoid_index_q == n_q - CB'(1)) begin
          state_d = tpi_pkg::S_DONE;
        end else begin
          state_d = tpi_pkg::S_POINT;
        end
      end
      tpi_pkg::S_DONE: begin
        if (res_load) begin
          state_d = tpi_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tpi_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    req_i.ready = 1'b0;
    res_load    = 1'b0;
    case (state_q)
      tpi_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
      end
      tpi_pkg::S_DONE: begin
        // The result register takes the sum once its previous beat is gone.
        res_load = !res_valid_q || res_o.ready;
      end
      default: begin
        req_i.ready = 1'b0;
        res_load    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpi_pkg::S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_integral_q <= sum_accumulator_q[tpi_pkg::ACC_W-1:16];
    end
    case (state_q)
      tpi_pkg::S_IDLE: begin
        if (req_beat) begin
          n_q               <= CB'(req_i.trapezoid_count);
          w_q               <= req_i.step_width;
          x_q               <= tpi_pkg::X_W'(req_i.step_width);
          left_height_q     <= tpi_pkg::HEIGHT_AT_ZERO;
          sum_accumulator_q <= '0;
          trapezoid_index_q <= '0;
        end
      end
      tpi_pkg::S_POINT: begin
        // Start the square of the right-hand sample point, or skip to a zero height.
        mcand_q   <= tpi_pkg::PROD_W'(x_round[47:16]);
        mplier_q  <= x_round[47:16];
        prod_q    <= '0;
        bit_cnt_q <= '0;
        if (x_far) begin
          quo_q <= '0;
        end
      end
      tpi_pkg::S_SQR, tpi_pkg::S_TRM: begin
        if (mplier_q[0]) begin
          prod_q <= prod_q + mcand_q;
        end
        mcand_q   <= {mcand_q[tpi_pkg::PROD_W-2:0], 1'b0};
        mplier_q  <= {1'b0, mplier_q[tpi_pkg::MUL_STEPS-1:1]};
        bit_cnt_q <= bit_cnt_q + tpi_pkg::CNT_W'(1);
      end
      tpi_pkg::S_SQCHK: begin
        div_q     <= prod_q[tpi_pkg::DIV_W-1:0] + tpi_pkg::DIV_OFFSET;
        rem_q     <= tpi_pkg::DIV_SEED;
        bit_cnt_q <= '0;
        if (sq_over) begin
          quo_q <= '0;
        end
      end
      tpi_pkg::S_DIV: begin
        rem_q     <= rem_ge ? rem_diff[tpi_pkg::DIV_W-1:0] : rem_shift[tpi_pkg::DIV_W-1:0];
        quo_q     <= {quo_q[tpi_pkg::HEIGHT_W-2:0], rem_ge};
        bit_cnt_q <= bit_cnt_q + tpi_pkg::CNT_W'(1);
      end
      tpi_pkg::S_TSET: begin
        // Term multiply: (left + right) * w, the right height sits in the quotient.
        mcand_q   <= tpi_pkg::PROD_W'({1'b0, left_height_q} + {1'b0, quo_q});
        mplier_q  <= w_q;
        prod_q    <= '0;
        bit_cnt_q <= '0;
      end
      tpi_pkg::S_ACC: begin
        sum_accumulator_q <= acc_sum[tpi_pkg::ACC_W] ? tpi_pkg::ACC_MAX
                                                     : acc_sum[tpi_pkg::ACC_W-1:0];
        left_height_q     <= quo_q;
        trapezoid_index_q <= trapezoid_index_q + CB'(1);
        x_q               <= x_q + tpi_pkg::X_W'(w_q);
      end
      default: begin
      end
    endcase
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.integral = res_integral_q;

endmodule

`default_nettype wire

### rtl/tpi_checker.sv
// Port-level checker of the trapezoid pi integrator and its bind statement.
`default_nettype none

`include "trapezoid_pi_integrator_defines.svh"

module tpi_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            req_valid_i,
  input wire logic                            req_ready_i,
  input wire logic                            res_valid_i,
  input wire logic                            res_ready_i,
  input wire logic [tpi_pkg::INTEGRAL_W-1:0]  res_integral_i
);

  // A request beat makes the block busy in the next cycle.
  `TPI_ASSERT_NEXT(a_busy_after_req, req_valid_i && req_ready_i, !req_ready_i)

  // No result appears in the cycle right after its request beat.
  `TPI_ASSERT_SAME(a_no_instant_res, $rose(res_valid_i), !$past(req_valid_i && req_ready_i))

  // A stalled result beat stays offered and unchanged.
  `TPI_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i)
  `TPI_ASSERT_NEXT(a_res_stable, res_valid_i && !res_ready_i, $stable(res_integral_i))

endmodule

bind trapezoid_pi_integrator tpi_checker u_tpi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_integral_i (res_o.integral)
);

`default_nettype wire
